// ----- sv/box_mean_filter_valid_region_defines.svh -----
// assertion helpers for the self-checking top level
`ifndef BOX_MEAN_FILTER_VALID_REGION_DEFINES_SVH
`define BOX_MEAN_FILTER_VALID_REGION_DEFINES_SVH

// condition that holds at every edge out of reset
`define BMF_ASSERT_ALWAYS(name, cond) \
   name: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("bmf check failed");

// same-cycle implication
`define BMF_ASSERT_IMPLIES(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bmf check failed");

`endif

// ----- sv/bmf_pkg.sv -----
package bmf_pkg;

   localparam int CFG_W       = 11;
   localparam int POS_W       = 13;
   localparam int KERN_W      = 5;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   localparam logic [1:0] CSR_IMAGE_WIDTH   = 2'd0;
   localparam logic [1:0] CSR_IMAGE_HEIGHT  = 2'd1;
   localparam logic [1:0] CSR_KERNEL_WIDTH  = 2'd2;
   localparam logic [1:0] CSR_KERNEL_HEIGHT = 2'd3;

   typedef struct packed {
      logic [7:0]        pixel;
      logic [POS_W-1:0]  row;
      logic [POS_W-1:0]  col;
      logic [KERN_W-1:0] slot;
      logic [KERN_W-1:0] kw;
      logic [KERN_W-1:0] kh;
      logic              emit;
      logic              last;
   } item_type;

   typedef struct packed {
      logic [QCNT_W-1:0] count;
      logic              full;
      logic              empty;
   } queue_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_ACCUM,
      ST_WRITE,
      ST_SUM,
      ST_DIVIDE,
      ST_OUTPUT
   } back_state_type;

endpackage

// ----- sv/bmf_front.sv -----
module bmf_front import bmf_pkg::*; #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int MAX_KERNEL = 15
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_enable,
   input  logic [1:0]       csr_index,
   input  logic [CFG_W-1:0] csr_write_data,
   input  logic             req_valid,
   input  logic [7:0]       req_pixel,
   input  logic             req_frame_start,
   output logic             req_stall,
   input  logic             queue_full,
   output logic             push,
   output item_type         push_item
);

   localparam int CW         = $clog2(MAX_WIDTH);
   localparam int RW         = $clog2(MAX_HEIGHT);
   localparam int LINE_SLOTS = MAX_KERNEL - 1;
   localparam int SL_W       = $clog2(LINE_SLOTS);
   localparam int KC_W       = $clog2(MAX_KERNEL + 1);

   logic [CFG_W-1:0] img_w_ff, img_h_ff;
   logic [3:0]       ker_w_ff, ker_h_ff;
   logic [CW-1:0]    col_ff, col_in;
   logic [RW-1:0]    row_ff, row_in;
   logic [SL_W-1:0]  slot_ff, slot_in;

   logic [CW:0]      w, c1, cn;
   logic [RW:0]      h, r1, rn;
   logic [KC_W-1:0]  kw, kh;
   logic [SL_W-1:0]  s1;

   function automatic logic [SL_W-1:0] slot_inc(input logic [SL_W-1:0] s);
      slot_inc = (s == SL_W'(LINE_SLOTS - 1)) ? '0 : s + 1'b1;
   endfunction

   // clamp sizes: zero reads as one, large values saturate
   always_comb begin
      if (img_w_ff == '0) w = (CW+1)'(1);
      else if (32'(img_w_ff) > MAX_WIDTH) w = (CW+1)'(MAX_WIDTH);
      else w = (CW+1)'(img_w_ff);
      if (img_h_ff == '0) h = (RW+1)'(1);
      else if (32'(img_h_ff) > MAX_HEIGHT) h = (RW+1)'(MAX_HEIGHT);
      else h = (RW+1)'(img_h_ff);
      if (ker_w_ff == '0) kw = KC_W'(1);
      else if (32'(ker_w_ff) > MAX_KERNEL) kw = KC_W'(MAX_KERNEL);
      else kw = KC_W'(ker_w_ff);
      if (ker_h_ff == '0) kh = KC_W'(1);
      else if (32'(ker_h_ff) > MAX_KERNEL) kh = KC_W'(MAX_KERNEL);
      else kh = KC_W'(ker_h_ff);
   end

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   // position of this pixel and of the next one
   always_comb begin
      c1 = req_frame_start ? '0 : {1'b0, col_ff};
      r1 = req_frame_start ? '0 : {1'b0, row_ff};
      s1 = req_frame_start ? '0 : slot_ff;
      if (c1 >= w) begin
         c1 = '0;
         r1 = r1 + 1'b1;
         s1 = slot_inc(s1);
      end
      if (r1 >= h) begin
         r1 = '0;
         s1 = '0;
      end
      cn = c1 + 1'b1;
      rn = r1 + 1'b1;
      if (cn >= w) begin
         col_in = '0;
         if (rn >= h) begin
            row_in  = '0;
            slot_in = '0;
         end else begin
            row_in  = rn[RW-1:0];
            slot_in = slot_inc(s1);
         end
      end else begin
         col_in  = cn[CW-1:0];
         row_in  = r1[RW-1:0];
         slot_in = s1;
      end
      push_item.pixel = req_pixel;
      push_item.row   = POS_W'(r1);
      push_item.col   = POS_W'(c1);
      push_item.slot  = KERN_W'(s1);
      push_item.kw    = KERN_W'(kw);
      push_item.kh    = KERN_W'(kh);
      push_item.emit  = (32'(r1) + 1 >= 32'(kh)) && (32'(c1) + 1 >= 32'(kw));
      push_item.last  = (32'(r1) == 32'(h) - 1) && (32'(c1) == 32'(w) - 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         img_w_ff <= CFG_W'(1024);
         img_h_ff <= CFG_W'(1024);
         ker_w_ff <= 4'd3;
         ker_h_ff <= 4'd3;
         col_ff   <= '0;
         row_ff   <= '0;
         slot_ff  <= '0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_IMAGE_WIDTH:   img_w_ff <= csr_write_data;
               CSR_IMAGE_HEIGHT:  img_h_ff <= csr_write_data;
               CSR_KERNEL_WIDTH:  ker_w_ff <= csr_write_data[3:0];
               CSR_KERNEL_HEIGHT: ker_h_ff <= csr_write_data[3:0];
               default: ;
            endcase
         end
         if (push) begin
            col_ff  <= col_in;
            row_ff  <= row_in;
            slot_ff <= slot_in;
         end
      end
   end

endmodule

// ----- sv/bmf_queue.sv -----
module bmf_queue import bmf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  item_type         push_item,
   input  logic             pop,
   output item_type         head_item,
   output queue_status_type status
);

   item_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;

   assign head_item    = entry_ff[rd_ptr_ff];
   assign status.count = count_ff;
   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (push && !pop)      count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
   end

endmodule

// ----- sv/bmf_back.sv -----
module bmf_back import bmf_pkg::*; #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_KERNEL = 15
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       queue_empty,
   input  item_type   head_item,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_mean_value,
   output logic [9:0] rsp_out_row,
   output logic [9:0] rsp_out_col,
   output logic       rsp_frame_last
);

   localparam int CW         = $clog2(MAX_WIDTH);
   localparam int LINE_SLOTS = MAX_KERNEL - 1;
   localparam int SL_W       = $clog2(LINE_SLOTS);
   localparam int MEM_DEPTH  = LINE_SLOTS << CW;
   localparam int AW         = SL_W + CW;
   localparam int KC_W       = $clog2(MAX_KERNEL + 1);
   localparam int KI_W       = $clog2(MAX_KERNEL);
   localparam int CS_W       = $clog2(MAX_KERNEL * 255 + 1);
   localparam int WS_W       = $clog2(MAX_KERNEL * MAX_KERNEL * 255 + 1);
   localparam int AR_W       = $clog2(MAX_KERNEL * MAX_KERNEL + 1);
   localparam int DV_W       = WS_W + 8;

   back_state_type  state_ff, state_in;
   item_type        item_ff, item_in;
   logic [KC_W-1:0] k_ff, k_in;
   logic [SL_W-1:0] rslot_ff, rslot_in, rslot_dec;
   logic [CS_W-1:0] csum_ff, csum_in;
   logic [CS_W-1:0] cs_ff [MAX_KERNEL];
   logic            cs_shift;
   logic [WS_W-1:0] wsum_ff, wsum_in, rem_ff, rem_in;
   logic [AR_W-1:0] area_ff, area_in;
   logic [7:0]      quot_ff, quot_in;
   logic [2:0]      bit_ff, bit_in;
   logic [DV_W-1:0] dvs;

   logic [7:0]      row_store [MEM_DEPTH];
   logic [7:0]      rd_data_ff;
   logic [AW-1:0]   mem_addr;
   logic            mem_re, mem_we;

   logic            out_load;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [7:0]      mean_ff;
   logic [9:0]      orow_ff, ocol_ff;
   logic            last_ff;

   logic [KC_W-1:0] kw_c, kh_c;
   logic [CW-1:0]   col_c;

   assign kw_c      = KC_W'(item_ff.kw);
   assign kh_c      = KC_W'(item_ff.kh);
   assign col_c     = item_ff.col[CW-1:0];
   assign rslot_dec = (rslot_ff == '0) ? SL_W'(LINE_SLOTS - 1) : rslot_ff - 1'b1;
   assign dvs       = DV_W'(area_ff) << bit_ff;

   always_comb begin
      state_in = state_ff;
      item_in  = item_ff;
      k_in     = k_ff;
      rslot_in = rslot_ff;
      csum_in  = csum_ff;
      wsum_in  = wsum_ff;
      area_in  = area_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      bit_in   = bit_ff;
      pop      = 1'b0;
      mem_re   = 1'b0;
      mem_we   = 1'b0;
      mem_addr = {item_ff.slot[SL_W-1:0], col_c};
      cs_shift = 1'b0;
      out_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               pop      = 1'b1;
               item_in  = head_item;
               csum_in  = CS_W'(head_item.pixel);
               k_in     = KC_W'(1);
               rslot_in = head_item.slot[SL_W-1:0];
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            // walk the rows above this pixel, newest first
            if (k_ff < kh_c && 32'(k_ff) <= 32'(item_ff.row)) begin
               mem_re   = 1'b1;
               mem_addr = {rslot_dec, col_c};
               rslot_in = rslot_dec;
               state_in = ST_ACCUM;
            end else begin
               state_in = ST_WRITE;
            end
         end
         ST_ACCUM: begin
            csum_in  = csum_ff + CS_W'(rd_data_ff);
            k_in     = k_ff + 1'b1;
            state_in = ST_READ;
         end
         ST_WRITE: begin
            mem_we   = 1'b1;
            cs_shift = 1'b1;
            k_in     = '0;
            wsum_in  = '0;
            area_in  = AR_W'(32'(kw_c) * 32'(kh_c));
            state_in = item_ff.emit ? ST_SUM : ST_IDLE;
         end
         ST_SUM: begin
            if (k_ff < kw_c) begin
               wsum_in = wsum_ff + WS_W'(cs_ff[k_ff[KI_W-1:0]]);
               k_in    = k_ff + 1'b1;
            end else begin
               rem_in   = wsum_ff;
               quot_in  = '0;
               bit_in   = 3'd7;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            // restoring division, one quotient bit per cycle
            if (DV_W'(rem_ff) >= dvs) begin
               rem_in          = WS_W'(DV_W'(rem_ff) - dvs);
               quot_in[bit_ff] = 1'b1;
            end
            bit_in = bit_ff - 1'b1;
            if (bit_ff == '0) state_in = ST_OUTPUT;
         end
         ST_OUTPUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (out_load)        rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
      else                 rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) row_store[mem_addr] <= item_ff.pixel;
      if (mem_re) rd_data_ff <= row_store[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (cs_shift) begin
         cs_ff[0] <= csum_ff;
         for (int i = 1; i < MAX_KERNEL; i++) cs_ff[i] <= cs_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      k_ff     <= k_in;
      rslot_ff <= rslot_in;
      csum_ff  <= csum_in;
      wsum_ff  <= wsum_in;
      area_ff  <= area_in;
      rem_ff   <= rem_in;
      quot_ff  <= quot_in;
      bit_ff   <= bit_in;
      if (out_load) begin
         mean_ff <= quot_ff;
         orow_ff <= 10'(32'(item_ff.row) - 32'(kh_c) + 1);
         ocol_ff <= 10'(32'(item_ff.col) - 32'(kw_c) + 1);
         last_ff <= item_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_mean_value = mean_ff;
   assign rsp_out_row    = orow_ff;
   assign rsp_out_col    = ocol_ff;
   assign rsp_frame_last = last_ff;

endmodule

// ----- sv/box_mean_filter_valid_region.sv -----
// box mean filter over the valid region of a raster-order grey image
// request channel: req_valid/req_stall carry one 8-bit pixel per transfer,
// req_frame_start marks the first pixel of a frame
// response channel: rsp_valid/rsp_stall carry one mean per full window,
// with its row and column in the reduced image and a last-of-frame flag
// csr port: write-only, index 0..3 = image width, height, kernel w, h;
// write only while no pixel is in flight
// the front end tracks position and takes a pixel whenever the 4-deep
// queue has room; the back end handles one pixel at a time: it pops it,
// reads and adds the stored pixels of up to kh-1 rows above, one read
// at a time from the single-port line store, writes the new pixel, and
// when a window completes sums kw column sums, runs the 8-step divider
// and loads the output register
// reset: sizes return to 1024x1024 with a 3x3 kernel, position to 0,0,
// queue empty, no response pending; line store contents are not cleared
// a stalled response holds in the output register while the back end
// keeps working; it stops only when its next result cannot be loaded
`include "box_mean_filter_valid_region_defines.svh"

module box_mean_filter_valid_region import bmf_pkg::*; #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int MAX_KERNEL = 15
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_enable,
   input  logic [1:0]       csr_index,
   input  logic [CFG_W-1:0] csr_write_data,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_pixel,
   input  logic             req_frame_start,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_mean_value,
   output logic [9:0]       rsp_out_row,
   output logic [9:0]       rsp_out_col,
   output logic             rsp_frame_last
);

   // front to queue
   logic             q_push;
   item_type         q_push_item;
   // queue to back
   logic             q_pop;
   item_type         q_head;
   queue_status_type q_status;

   // position tracking, size clamping, csr registers
   bmf_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .MAX_KERNEL (MAX_KERNEL)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_pixel        (req_pixel),
      .req_frame_start  (req_frame_start),
      .req_stall        (req_stall),
      .queue_full       (q_status.full),
      .push             (q_push),
      .push_item        (q_push_item)
   );

   // decouples pixel intake from the multi-cycle window work
   bmf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .pop       (q_pop),
      .head_item (q_head),
      .status    (q_status)
   );

   // line store, column sums, window sum, divider, output register
   bmf_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_KERNEL (MAX_KERNEL)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .queue_empty    (q_status.empty),
      .head_item      (q_head),
      .pop            (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_mean_value (rsp_mean_value),
      .rsp_out_row    (rsp_out_row),
      .rsp_out_col    (rsp_out_col),
      .rsp_frame_last (rsp_frame_last)
   );

   // intake must back off once the queue is full
   `BMF_ASSERT_IMPLIES(a_stall_when_full, q_status.full, req_stall)
   // the back end never takes from an empty queue
   `BMF_ASSERT_IMPLIES(a_pop_not_empty, q_pop, !q_status.empty)
   // occupancy stays within the queue
   `BMF_ASSERT_ALWAYS(a_count_bound, q_status.count <= QCNT_W'(QUEUE_DEPTH))

endmodule
